>>> rtl/sksw_pkg.sv
package sksw_pkg;

  localparam int unsigned NUM_WORDS    = 6;
  localparam int unsigned MAX_WORD_LEN = 4;

  localparam int unsigned LEN_BITS = 3;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_WORDS = 2'd1,
    STATUS_EMPTY    = 2'd2
  } status_e;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_END  = 1'b1
  } op_e;

  typedef struct packed {
    logic is_sep;
    logic tok_start;
    logic in_run;
  } dec_flags_t;

endpackage

>>> rtl/split_keep_separator_words.sv
// Splits a byte string into tokens, keeping each separator word as a token.
// The slave stream carries one item per string byte (tuser op = byte) and one
// end marker item per string (tuser op = end). The master stream gives one
// item per string byte with separator and token-start flags, plus status
// items for an empty string or when no separator words are configured.
// Words and lengths are written through the plain register write port; the user
// must write them only while no string is in flight, which the block does not enforce.
// A byte item is taken in every cycle while the output can advance and no flush runs.
// Its result is the byte that arrived MAX_WORD_LEN-1 items earlier and appears in
// the cycle after the item is taken; the first MAX_WORD_LEN-1 bytes of a string
// give no result. An end marker flushes the held bytes from the lookahead register,
// one result per cycle while the receiver takes them, giving up to MAX_WORD_LEN-1
// results; no new item is taken until the flush is done.
// A single output register holds the result; while the receiver stalls it
// keeps its item and the block stops taking items until it is taken.
// Reset clears the config registers, the fill and run state and the output valid flag.
module split_keep_separator_words import sksw_pkg::*; #(
  parameter int unsigned NW = NUM_WORDS,
  parameter int unsigned ML = MAX_WORD_LEN,
  parameter int unsigned CW = ((8 * ML) > (LEN_BITS * NW)) ? (8 * ML) : (LEN_BITS * NW),
  parameter int unsigned IDXW = $clog2(NW + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [IDXW-1:0] cfg_idx_i,
  input  logic [CW-1:0]   cfg_wdata_i,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [7:0]      s_axis_tdata_i,  // in_byte[7:0]
  input  logic [0:0]      s_axis_tuser_i,  // op[0]
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [15:0]     m_axis_tdata_o,  // out_byte[7:0], status[9:8], zeros
  output logic [2:0]      m_axis_tuser_o,  // is_separator[0], token_start[1], last_of_item[2]
  output logic            m_axis_tlast_o   // end_of_string
);

  localparam int unsigned AW  = $clog2(ML + 1);
  localparam int unsigned SW  = (ML > 1) ? $clog2(ML) : 1;
  localparam int unsigned FW  = (ML > 1) ? $clog2(ML) : 1;
  localparam int unsigned LAD = (ML > 1) ? (ML - 1) : 1;

  logic [8*ML-1:0] words [NW];
  logic [AW-1:0]   lens [NW];
  logic [NW-1:0]   active;
  logic            none;

  logic [7:0]    la_q [LAD];
  logic [7:0]    la_d [LAD];
  logic [FW-1:0] fill_q, fill_d;
  logic [SW-1:0] sep_rem_q, sep_rem_d;
  logic          in_run_q, in_run_d;
  logic          seen_q, seen_d;
  logic          flush_q, flush_d;

  logic          out_v_q;
  logic [7:0]    out_byte_q, out_byte_d;
  logic          out_sep_q, out_sep_d;
  logic          out_st_q, out_st_d;
  logic          out_end_q, out_end_d;
  status_e       out_status_q, out_status_d;
  logic          out_last_q, out_last_d;

  logic          adv, acc, is_end, emit, do_flush;
  logic [7:0]    win [ML];
  logic [AW-1:0] avail;
  logic [SW-1:0] dec_sep_rem;
  dec_flags_t    dec_flags;

  sksw_cfg #(.NW(NW), .ML(ML), .CW(CW), .IDXW(IDXW), .AW(AW)) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .words_o    (words),
    .lens_o     (lens),
    .active_o   (active),
    .none_o     (none)
  );

  assign adv             = ~out_v_q | m_axis_tready_i;
  assign s_axis_tready_o = adv & ~flush_q;
  assign acc             = s_axis_tvalid_i & s_axis_tready_o;
  assign is_end          = (op_e'(s_axis_tuser_i[0]) == OP_END);
  assign do_flush        = (flush_q & adv) | (acc & is_end & ~none & seen_q & (fill_q != '0));

  always_comb begin
    for (int k = 0; k < ML; k++) begin
      win[k] = '0;
    end
    for (int k = 0; k < ML - 1; k++) begin
      win[k] = la_q[k];
    end
    win[ML-1] = do_flush ? 8'h00 : s_axis_tdata_i;
    avail     = do_flush ? AW'(fill_q) : AW'(ML);
  end

  sksw_match #(.NW(NW), .ML(ML), .AW(AW), .SW(SW)) u_match (
    .win_i    (win),
    .avail_i  (avail),
    .words_i  (words),
    .lens_i   (lens),
    .active_i (active),
    .sep_rem_i(sep_rem_q),
    .in_run_i (in_run_q),
    .sep_rem_o(dec_sep_rem),
    .flags_o  (dec_flags)
  );

  always_comb begin
    la_d         = la_q;
    fill_d       = fill_q;
    sep_rem_d    = sep_rem_q;
    in_run_d     = in_run_q;
    seen_d       = seen_q;
    flush_d      = flush_q;
    emit         = 1'b0;
    out_byte_d   = win[0];
    out_sep_d    = dec_flags.is_sep;
    out_st_d     = dec_flags.tok_start;
    out_end_d    = 1'b0;
    out_status_d = STATUS_OK;
    out_last_d   = 1'b0;
    if (do_flush) begin
      emit      = 1'b1;
      sep_rem_d = dec_sep_rem;
      in_run_d  = dec_flags.in_run;
      for (int k = 0; k < ML - 2; k++) begin
        la_d[k] = la_q[k+1];
      end
      fill_d = fill_q - FW'(1);
      if (fill_q == FW'(1)) begin
        out_end_d  = 1'b1;
        out_last_d = 1'b1;
        fill_d     = '0;
        sep_rem_d  = '0;
        in_run_d   = 1'b0;
        seen_d     = 1'b0;
        flush_d    = 1'b0;
      end else begin
        flush_d = 1'b1;
      end
    end else if (acc && !is_end) begin
      seen_d = 1'b1;
      if (!none) begin
        if (fill_q < FW'(ML - 1)) begin
          for (int k = 0; k < ML - 1; k++) begin
            if (fill_q == FW'(k)) begin
              la_d[k] = s_axis_tdata_i;
            end
          end
          fill_d = fill_q + FW'(1);
        end else begin
          emit       = 1'b1;
          out_last_d = 1'b1;
          sep_rem_d  = dec_sep_rem;
          in_run_d   = dec_flags.in_run;
          for (int k = 0; k < ML - 1; k++) begin
            la_d[k] = win[k+1];
          end
        end
      end
    end else if (acc) begin
      emit       = 1'b1;
      out_byte_d = '0;
      out_sep_d  = 1'b0;
      out_st_d   = 1'b0;
      out_end_d  = 1'b1;
      out_last_d = 1'b1;
      priority if (none) begin
        out_status_d = STATUS_NO_WORDS;
      end else if (!seen_q) begin
        out_status_d = STATUS_EMPTY;
      end else begin
        out_status_d = STATUS_OK;
      end
      fill_d    = '0;
      sep_rem_d = '0;
      in_run_d  = 1'b0;
      seen_d    = 1'b0;
      flush_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      sep_rem_q <= '0;
      in_run_q  <= 1'b0;
      seen_q    <= 1'b0;
      flush_q   <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      fill_q    <= fill_d;
      sep_rem_q <= sep_rem_d;
      in_run_q  <= in_run_d;
      seen_q    <= seen_d;
      flush_q   <= flush_d;
      if (adv) begin
        out_v_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    la_q <= la_d;
    if (adv && emit) begin
      out_byte_q   <= out_byte_d;
      out_sep_q    <= out_sep_d;
      out_st_q     <= out_st_d;
      out_end_q    <= out_end_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {6'b0, out_status_q, out_byte_q};
  assign m_axis_tuser_o  = {out_last_q, out_st_q, out_sep_q};
  assign m_axis_tlast_o  = out_end_q;

endmodule

>>> rtl/sksw_cfg.sv
module sksw_cfg import sksw_pkg::*; #(
  parameter int unsigned NW   = NUM_WORDS,
  parameter int unsigned ML   = MAX_WORD_LEN,
  parameter int unsigned CW   = ((8 * ML) > (LEN_BITS * NW)) ? (8 * ML) : (LEN_BITS * NW),
  parameter int unsigned IDXW = $clog2(NW + 1),
  parameter int unsigned AW   = $clog2(ML + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [IDXW-1:0]       cfg_idx_i,
  input  logic [CW-1:0]         cfg_wdata_i,
  output logic [8*ML-1:0]       words_o [NW],
  output logic [AW-1:0]         lens_o [NW],
  output logic [NW-1:0]         active_o,
  output logic                  none_o
);

  logic [8*ML-1:0]       words_q [NW];
  logic [LEN_BITS*NW-1:0] lens_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NW; i++) begin
        words_q[i] <= '0;
      end
      lens_q <= '0;
    end else if (cfg_we_i) begin
      for (int i = 0; i < NW; i++) begin
        if (cfg_idx_i == IDXW'(i)) begin
          words_q[i] <= cfg_wdata_i[8*ML-1:0];
        end
      end
      if (cfg_idx_i == IDXW'(NW)) begin
        lens_q <= cfg_wdata_i[LEN_BITS*NW-1:0];
      end
    end
  end

  always_comb begin
    logic [LEN_BITS-1:0] raw;
    logic                run;
    run = 1'b1;
    for (int i = 0; i < NW; i++) begin
      raw = lens_q[LEN_BITS*i +: LEN_BITS];
      if ({1'b0, raw} > 4'(ML)) begin
        lens_o[i] = AW'(ML);
      end else begin
        lens_o[i] = AW'(raw);
      end
      run         = run && (raw != '0);
      active_o[i] = run;
      words_o[i]  = words_q[i];
    end
    none_o = ~active_o[0];
  end

endmodule

>>> rtl/sksw_match.sv
module sksw_match import sksw_pkg::*; #(
  parameter int unsigned NW = NUM_WORDS,
  parameter int unsigned ML = MAX_WORD_LEN,
  parameter int unsigned AW = $clog2(ML + 1),
  parameter int unsigned SW = (ML > 1) ? $clog2(ML) : 1
) (
  input  logic [7:0]      win_i [ML],
  input  logic [AW-1:0]   avail_i,
  input  logic [8*ML-1:0] words_i [NW],
  input  logic [AW-1:0]   lens_i [NW],
  input  logic [NW-1:0]   active_i,
  input  logic [SW-1:0]   sep_rem_i,
  input  logic            in_run_i,
  output logic [SW-1:0]   sep_rem_o,
  output dec_flags_t      flags_o
);

  logic [NW-1:0] hit;

  always_comb begin
    for (int i = 0; i < NW; i++) begin
      hit[i] = active_i[i] && (lens_i[i] <= avail_i);
      for (int j = 0; j < ML; j++) begin
        if ((AW'(j) < lens_i[i]) && (words_i[i][8*j +: 8] != win_i[j])) begin
          hit[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    logic          found;
    logic [AW-1:0] sel_len;
    found   = 1'b0;
    sel_len = '0;
    for (int i = 0; i < NW; i++) begin
      if (hit[i] && !found) begin
        found   = 1'b1;
        sel_len = lens_i[i];
      end
    end
    sep_rem_o = sep_rem_i;
    flags_o   = '{is_sep: 1'b0, tok_start: 1'b0, in_run: in_run_i};
    priority if (sep_rem_i != '0) begin
      sep_rem_o      = sep_rem_i - SW'(1);
      flags_o.is_sep = 1'b1;
    end else if (found) begin
      sep_rem_o         = SW'(sel_len - AW'(1));
      flags_o.is_sep    = 1'b1;
      flags_o.tok_start = 1'b1;
      flags_o.in_run    = 1'b0;
    end else begin
      flags_o.tok_start = ~in_run_i;
      flags_o.in_run    = 1'b1;
    end
  end

endmodule
